FILE: hw/rtl/bsa_pkg.sv
// bsa_pkg: sizes, item types and the bin entry layout of the binned stats accumulator
// used by every module of the block but bsa_bin_ram, depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package bsa_pkg;

  localparam int PLANES  = 4;
  localparam int STATS   = 8;
  localparam int COLUMNS = 64;
  localparam int NBINS   = PLANES * STATS * COLUMNS;
  localparam int AW      = (NBINS > 1) ? $clog2(NBINS) : 1;

  // shared divider and square root sizes
  localparam int DIV_NW = 78;
  localparam int DIV_DW = 24;
  localparam int SQ_W   = 64;

  localparam logic FUNC_ACC  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic              func;
    logic signed [23:0] sample;
    logic [1:0]        plane_sel;
    logic [2:0]        stat_sel;
    logic [5:0]        column_sel;
  } in_item_t;

  typedef struct packed {
    logic signed [39:0] sum_out;
    logic [15:0]        count_out;
    logic [22:0]        max_out;
    logic signed [23:0] min_out;
    logic signed [31:0] avg_out;
    logic [31:0]        stdev_out;
    logic signed [31:0] avg_over_max;
    logic               zero_divisor;
  } out_item_t;

  typedef struct packed {
    logic signed [39:0] sum;
    logic [15:0]        count;
    logic signed [23:0] max;
    logic signed [23:0] min;
    logic               has_min;
    logic [61:0]        sumsq;
  } bin_entry_t;

  localparam int ENTRY_W = $bits(bin_entry_t);

endpackage

`default_nettype wire

FILE: hw/rtl/bsa_bin_ram.sv
// bsa_bin_ram: generic single write, single read port ram with registered read data
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module bsa_bin_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                   wr_data,
  input  wire logic                               rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                   rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bsa_div.sv
// bsa_div: restoring unsigned divider, one quotient bit per cycle
// depends on bsa_pkg for operand widths
`timescale 1ns / 1ps
`default_nettype none

module bsa_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [bsa_pkg::DIV_NW-1:0] dividend,
  input  wire logic [bsa_pkg::DIV_DW-1:0] divisor,
  output logic                            done,
  output logic      [bsa_pkg::DIV_NW-1:0] quotient
);
  import bsa_pkg::*;

  localparam int CW = $clog2(DIV_NW + 1);

  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] dsr_r;
  logic [DIV_NW-1:0] quo_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {rem_r, quo_r[DIV_NW-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      done_r <= 1'b0;
      rem_r  <= '0;
      quo_r  <= dividend;
      dsr_r  <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? DIV_DW'(trial - {1'b0, dsr_r}) : DIV_DW'(trial);
      quo_r <= {quo_r[DIV_NW-2:0], fits};
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(DIV_NW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        done_r <= 1'b0;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

FILE: hw/rtl/bsa_sqrt.sv
// bsa_sqrt: floor square root, two radicand bits per cycle
// depends on bsa_pkg for the radicand width
`timescale 1ns / 1ps
`default_nettype none

module bsa_sqrt (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [bsa_pkg::SQ_W-1:0] value,
  output logic                          done,
  output logic      [bsa_pkg::SQ_W/2-1:0] root
);
  import bsa_pkg::*;

  localparam int STEPS = SQ_W / 2;
  localparam int CW    = $clog2(STEPS);

  logic [SQ_W-1:0] v_r;
  logic [SQ_W-1:0] res_r;
  logic [SQ_W-1:0] bit_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [SQ_W-1:0] cand;

  assign cand = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      done_r <= 1'b0;
      v_r    <= value;
      res_r  <= '0;
      bit_r  <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy_r) begin
      if (v_r >= cand) begin
        v_r   <= v_r - cand;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        done_r <= 1'b0;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign done = done_r;
  assign root = res_r[SQ_W/2-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/binned_stats_accumulator.sv
// binned_stats_accumulator: top level, bin memory sequencer and read-out arithmetic
// depends on bsa_pkg, bsa_bin_ram, bsa_div and bsa_sqrt
`timescale 1ns / 1ps
`default_nettype none

// Per-bin running sum, count, sum of squares, maximum and nonzero minimum, kept in one
// on-chip memory of 2048 entries. One item is handled at a time. An accumulate item takes
// the memory read, then the write back of the updated entry. A read item takes the memory
// read, three passes of the shared 78-bit bit-serial divider (average, mean square,
// average over maximum), one multiply, one subtract and the square root unit, and its
// result is then registered; a bin with zero maximum skips the last division, and a bin
// with zero count or an item with an out-of-range selector skips the arithmetic. The
// result waits in an output register while later items are taken; a read that finishes
// while that register is still full waits for it. After reset a clearing pass writes
// zero into every entry, during which no item is accepted.
module binned_stats_accumulator (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire bsa_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output bsa_pkg::out_item_t       out_data
);
  import bsa_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_DAVG, S_DMSQ, S_MUL, S_VAR, S_SQRT, S_DAOM, S_FIN
  } state_t;

  state_t     state_r;
  logic [AW-1:0] clr_addr_r;
  in_item_t   item_r;
  logic       ok_r;
  logic [AW-1:0] addr_r;
  logic [47:0] sq_r;

  logic signed [39:0] sum_r;
  logic [15:0]        n_r;
  logic signed [23:0] mx_r;
  logic signed [23:0] mn_r;
  logic [61:0]        sumsq_r;
  logic signed [31:0] avg_r;
  logic [31:0]        am_r;
  logic [63:0]        msq_r;
  logic [63:0]        asq_r;
  logic [63:0]        var_r;
  logic [31:0]        sd_r;
  logic signed [31:0] aom_r;
  logic               zd_r;

  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               div_start_r;
  logic [DIV_NW-1:0]  div_dividend_r;
  logic [DIV_DW-1:0]  div_divisor_r;
  logic               div_done;
  logic [DIV_NW-1:0]  div_quo;
  logic               sq_start_r;
  logic               sq_done;
  logic [31:0]        sq_root;

  logic               in_fire;
  logic               in_ok;
  logic [AW-1:0]      in_addr;
  logic               ram_wr_en;
  logic [AW-1:0]      ram_wr_addr;
  bin_entry_t         ram_wr_ent;
  logic [ENTRY_W-1:0] ram_rd_raw;
  bin_entry_t         rd_ent;
  bin_entry_t         acc_ent;
  logic signed [40:0] ns;
  logic [62:0]        nsq;
  logic               sum_neg;
  logic [39:0]        sum_mag;

  function automatic logic signed [31:0] sat32(input logic neg, input logic [DIV_NW-1:0] mag);
    logic signed [31:0] r;
    if (neg) begin
      r = (mag >= DIV_NW'(64'h8000_0000)) ? 32'sh8000_0000 : 32'(-mag);
    end else begin
      r = (mag > DIV_NW'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : 32'(mag);
    end
    return r;
  endfunction

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_ok    = (int'(in_data.plane_sel) < PLANES) && (int'(in_data.stat_sel) < STATS)
                 && (int'(in_data.column_sel) < COLUMNS);
  assign in_addr  = in_ok ? AW'((int'(in_data.plane_sel) * STATS + int'(in_data.stat_sel))
                            * COLUMNS + int'(in_data.column_sel)) : '0;

  assign rd_ent = bin_entry_t'(ram_rd_raw);

  // accumulate update of the entry just read
  always_comb begin
    acc_ent = rd_ent;
    ns = 41'(rd_ent.sum) + 41'(item_r.sample);
    if (ns[40] != ns[39]) begin
      acc_ent.sum = ns[40] ? 40'sh80_0000_0000 : 40'sh7F_FFFF_FFFF;
    end else begin
      acc_ent.sum = ns[39:0];
    end
    if (rd_ent.count != 16'hFFFF) begin
      acc_ent.count = rd_ent.count + 16'd1;
    end
    nsq = 63'(rd_ent.sumsq) + 63'(sq_r);
    acc_ent.sumsq = nsq[62] ? '1 : nsq[61:0];
    if (item_r.sample > rd_ent.max) begin
      acc_ent.max = item_r.sample;
    end
    if (item_r.sample != 24'sd0 && (!rd_ent.has_min || item_r.sample < rd_ent.min)) begin
      acc_ent.min     = item_r.sample;
      acc_ent.has_min = 1'b1;
    end
  end

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = addr_r;
    ram_wr_ent  = acc_ent;
    if (state_r == S_CLEAR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_addr_r;
      ram_wr_ent  = '0;
    end else if (state_r == S_LOOK && item_r.func == FUNC_ACC && ok_r) begin
      ram_wr_en = 1'b1;
    end
  end

  assign sum_neg = rd_ent.sum < 40'sd0;
  assign sum_mag = sum_neg ? 40'(-rd_ent.sum) : 40'(rd_ent.sum);

  bsa_bin_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NBINS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_ent),
    .rd_en   (in_fire),
    .rd_addr (in_addr),
    .rd_data (ram_rd_raw)
  );

  bsa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dividend_r),
    .divisor  (div_divisor_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  bsa_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start_r),
    .value (var_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      sq_start_r  <= 1'b0;
    end else begin
      // a result leaving in the same cycle as a new one lands is replaced in S_FIN
      if (out_valid_r && out_ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == AW'(NBINS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            item_r  <= in_data;
            ok_r    <= in_ok;
            addr_r  <= in_addr;
            sq_r    <= 48'(in_data.sample) * 48'(in_data.sample);
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (item_r.func == FUNC_ACC) begin
            state_r <= S_IDLE;
          end else begin
            sum_r   <= ok_r ? rd_ent.sum : '0;
            n_r     <= ok_r ? rd_ent.count : '0;
            mx_r    <= ok_r ? rd_ent.max : '0;
            mn_r    <= (ok_r && rd_ent.has_min) ? rd_ent.min : '0;
            sumsq_r <= ok_r ? rd_ent.sumsq : '0;
            avg_r   <= '0;
            sd_r    <= '0;
            aom_r   <= '0;
            zd_r    <= 1'b1;
            if (!ok_r || rd_ent.count == 16'd0) begin
              state_r <= S_FIN;
            end else begin
              div_start_r    <= 1'b1;
              div_dividend_r <= DIV_NW'({sum_mag, 8'd0});
              div_divisor_r  <= DIV_DW'(rd_ent.count);
              state_r        <= S_DAVG;
            end
          end
        end
        S_DAVG: begin
          if (div_done) begin
            avg_r          <= sat32(sum_r < 40'sd0, div_quo);
            div_start_r    <= 1'b1;
            div_dividend_r <= DIV_NW'({sumsq_r, 16'd0});
            div_divisor_r  <= DIV_DW'(n_r);
            state_r        <= S_DMSQ;
          end else begin
            div_start_r <= 1'b0;
          end
        end
        S_DMSQ: begin
          div_start_r <= 1'b0;
          am_r <= avg_r[31] ? 32'(-avg_r) : 32'(avg_r);
          if (div_done) begin
            // mean square beyond 64 bits pins to all ones
            msq_r   <= (div_quo[DIV_NW-1:64] != '0) ? '1 : div_quo[63:0];
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          asq_r   <= 64'(am_r) * 64'(am_r);
          state_r <= S_VAR;
        end
        S_VAR: begin
          var_r      <= (msq_r >= asq_r) ? msq_r - asq_r : asq_r - msq_r;
          sq_start_r <= 1'b1;
          state_r    <= S_SQRT;
        end
        S_SQRT: begin
          sq_start_r <= 1'b0;
          if (sq_done) begin
            sd_r <= sq_root;
            if (mx_r > 24'sd0) begin
              zd_r           <= 1'b0;
              div_start_r    <= 1'b1;
              div_dividend_r <= DIV_NW'({am_r, 8'd0});
              div_divisor_r  <= DIV_DW'(mx_r);
              state_r        <= S_DAOM;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_DAOM: begin
          div_start_r <= 1'b0;
          if (div_done) begin
            aom_r   <= sat32(avg_r[31], div_quo);
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r             <= 1'b1;
            out_data_r.sum_out      <= sum_r;
            out_data_r.count_out    <= n_r;
            out_data_r.max_out      <= mx_r[22:0];
            out_data_r.min_out      <= mn_r;
            out_data_r.avg_out      <= avg_r;
            out_data_r.stdev_out    <= sd_r;
            out_data_r.avg_over_max <= aom_r;
            out_data_r.zero_divisor <= zd_r;
            state_r                 <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_item_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("item accepted during clearing pass");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DAVG || state_r == S_DMSQ || state_r == S_DAOM))
    else $error("divider finished outside a divide step");

  a_sqrt_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> (state_r == S_SQRT))
    else $error("square root finished outside its step");

  a_acc_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK && item_r.func == FUNC_ACC) |=> !(out_valid && !$past(out_valid)))
    else $error("accumulate item produced a result");

endmodule

`default_nettype wire
